[rtl/kct_pkg.sv]
// Package for the keyed counter table: request kinds, status codes, widths
// and the front-to-back request record. No dependencies.
package kct_pkg;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned IKEY_W   = 16;
    localparam int unsigned QTY_W    = 32;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned USED_W   = 7;
    localparam int unsigned SUM_W    = 38;

    // Request kinds; kind 3 is served as a query
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TAKE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT = 3'd1;
    localparam logic [STAT_W-1:0] ST_SHORT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_SAT    = 3'd4;

    // Request as it travels from the front to the back
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IKEY_W-1:0] key;
        logic [QTY_W-1:0]  qty;
    } t_req;

    // Back state machine
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } t_bk_state;

endpackage

[rtl/kct_front.sv]
// Front part of the keyed counter table: takes items, masks the key and
// queues them in a two-entry FIFO for the back part. Uses kct_pkg.
module kct_front #(
    parameter int unsigned KEY_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [kct_pkg::KIND_W-1:0] i_kind,
    input  logic [kct_pkg::IKEY_W-1:0] i_item_key,
    input  logic [kct_pkg::QTY_W-1:0]  i_quantity,
    output logic                      o_req_valid,
    input  logic                      i_req_take,
    output kct_pkg::t_req             o_req
);

    logic [KEY_BITS-1:0] key_cut;
    kct_pkg::t_req       in_req;
    kct_pkg::t_req       r_q [2];
    logic                r_rd, n_rd;
    logic                r_wr, n_wr;
    logic [1:0]          r_cnt, n_cnt;
    logic                push, pop;

    // classify: keep only the low KEY_BITS of the key
    always_comb begin
        key_cut = i_item_key[KEY_BITS-1:0];
        in_req.kind = i_kind;
        in_req.key  = kct_pkg::IKEY_W'(key_cut);
        in_req.qty  = i_quantity;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign pop         = i_req_take && (r_cnt != 2'd0);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rd];

    always_comb begin
        n_rd  = pop  ? ~r_rd : r_rd;
        n_wr  = push ? ~r_wr : r_wr;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_req;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue over-filled");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> o_stall) else $error("full queue not stalling");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_req_valid) else $error("empty queue shows request");

endmodule

[rtl/kct_back.sv]
// Back part of the keyed counter table: per-entry key compare, free-slot
// search, count update and the output register. Uses kct_pkg.
module kct_back #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned KEY_BITS      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_take,
    input  kct_pkg::t_req               i_req,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [kct_pkg::STAT_W-1:0]  o_status,
    output logic [kct_pkg::QTY_W-1:0]   o_held_amount,
    output logic                        o_has_enough,
    output logic [kct_pkg::USED_W-1:0]  o_entries_used,
    output logic [kct_pkg::SUM_W-1:0]   o_total_held
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned QW    = kct_pkg::QTY_W;

    kct_pkg::t_bk_state r_st, n_st;

    // entry storage: keys in flops (parallel compare), counts in a memory
    logic [KEY_BITS-1:0] r_key [TABLE_ENTRIES];
    logic [QW-1:0]       r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;
    logic [kct_pkg::USED_W-1:0] r_used;
    logic [kct_pkg::SUM_W-1:0]  r_sum;

    kct_pkg::t_req       r_req;
    logic                r_hit;
    logic [IDX_W-1:0]    r_slot;
    logic                r_free_ok;
    logic [IDX_W-1:0]    r_free;
    logic [QW-1:0]       r_cnt_rd;

    logic [TABLE_ENTRIES-1:0] match;
    logic                hit_c, free_c;
    logic [IDX_W-1:0]    slot_c, free_idx_c;
    logic [KEY_BITS-1:0] key_c;

    logic [QW-1:0]       cnt_old;
    logic [QW:0]         add_s;
    logic [QW-1:0]       new_cnt;
    logic                wr_en, set_v, clr_v, enough;
    logic [IDX_W-1:0]    wr_idx;
    logic [kct_pkg::STAT_W-1:0] stat_c;
    logic [QW-1:0]       held_c;
    logic [kct_pkg::SUM_W-1:0]  sum_c;
    logic [kct_pkg::USED_W-1:0] used_c;

    // output register
    logic                r_ov;
    logic [kct_pkg::STAT_W-1:0] r_ostat;
    logic [QW-1:0]       r_oheld;
    logic                r_oen;
    logic [kct_pkg::USED_W-1:0] r_oused;
    logic [kct_pkg::SUM_W-1:0]  r_osum;
    logic                out_free;

    assign out_free = !r_ov || !i_stall;
    assign key_c    = i_req.key[KEY_BITS-1:0];

    // parallel key compare and priority encoders
    always_comb begin
        hit_c = 1'b0;
        slot_c = '0;
        free_c = 1'b0;
        free_idx_c = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i] = r_vld[i] && (r_key[i] == key_c);
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_c  = 1'b1;
                slot_c = IDX_W'(i);
            end
            if (!r_vld[i]) begin
                free_c     = 1'b1;
                free_idx_c = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            kct_pkg::BK_IDLE: if (i_req_valid) n_st = kct_pkg::BK_READ;
            kct_pkg::BK_READ: n_st = kct_pkg::BK_EXEC;
            kct_pkg::BK_EXEC: if (out_free) n_st = kct_pkg::BK_IDLE;
            default:          n_st = kct_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_req_take = 1'b0;
        case (r_st)
            kct_pkg::BK_IDLE: o_req_take = i_req_valid;
            default:          o_req_take = 1'b0;
        endcase
    end

    // execute the request
    always_comb begin
        cnt_old = r_hit ? r_cnt_rd : '0;
        enough  = cnt_old >= r_req.qty;
        add_s   = {1'b0, cnt_old} + {1'b0, r_req.qty};
        stat_c  = kct_pkg::ST_OK;
        held_c  = cnt_old;
        new_cnt = cnt_old;
        wr_en   = 1'b0;
        set_v   = 1'b0;
        clr_v   = 1'b0;
        wr_idx  = r_slot;
        sum_c   = r_sum;
        used_c  = r_used;
        case (r_req.kind)
            kct_pkg::KIND_ADD: begin
                if (r_hit) begin
                    new_cnt = add_s[QW] ? '1 : add_s[QW-1:0];
                    if (add_s[QW]) stat_c = kct_pkg::ST_SAT;
                    wr_en  = 1'b1;
                    held_c = new_cnt;
                    sum_c  = r_sum + kct_pkg::SUM_W'(new_cnt - cnt_old);
                end else if (!r_free_ok) begin
                    stat_c = kct_pkg::ST_FULL;
                    held_c = '0;
                end else begin
                    wr_en   = 1'b1;
                    set_v   = 1'b1;
                    wr_idx  = r_free;
                    new_cnt = r_req.qty;
                    held_c  = r_req.qty;
                    used_c  = r_used + 1'b1;
                    sum_c   = r_sum + kct_pkg::SUM_W'(r_req.qty);
                end
            end
            kct_pkg::KIND_TAKE: begin
                if (!r_hit) begin
                    stat_c = kct_pkg::ST_ABSENT;
                    held_c = '0;
                end else if (!enough) begin
                    stat_c = kct_pkg::ST_SHORT;
                end else begin
                    new_cnt = cnt_old - r_req.qty;
                    held_c  = new_cnt;
                    wr_en   = 1'b1;
                    sum_c   = r_sum - kct_pkg::SUM_W'(r_req.qty);
                    if (new_cnt == '0) begin
                        clr_v  = 1'b1;
                        used_c = r_used - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= kct_pkg::BK_IDLE;
            r_vld  <= '0;
            r_used <= '0;
            r_sum  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == kct_pkg::BK_EXEC && out_free) begin
                r_used <= used_c;
                r_sum  <= sum_c;
                if (set_v) r_vld[wr_idx] <= 1'b1;
                if (clr_v) r_vld[wr_idx] <= 1'b0;
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // request capture, lookup results and key write
    always_ff @(posedge i_clk) begin
        if (o_req_take) begin
            r_req     <= i_req;
            r_hit     <= hit_c;
            r_slot    <= slot_c;
            r_free_ok <= free_c;
            r_free    <= free_idx_c;
        end
        if (r_st == kct_pkg::BK_EXEC && out_free && set_v) begin
            r_key[wr_idx] <= r_req.key[KEY_BITS-1:0];
        end
    end

    // count memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (r_st == kct_pkg::BK_READ) begin
            r_cnt_rd <= r_mem[r_slot];
        end
        if (r_st == kct_pkg::BK_EXEC && out_free && wr_en) begin
            r_mem[wr_idx] <= new_cnt;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_st == kct_pkg::BK_EXEC && out_free) begin
            r_ostat <= stat_c;
            r_oheld <= held_c;
            r_oen   <= enough;
            r_oused <= used_c;
            r_osum  <= sum_c;
        end
    end

    assign o_valid        = r_ov;
    assign o_status       = r_ostat;
    assign o_held_amount  = r_oheld;
    assign o_has_enough   = r_oen;
    assign o_entries_used = r_oused;
    assign o_total_held   = r_osum;

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match)) else $error("key held in two entries");
    a_used_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        TABLE_ENTRIES > 127 || r_used == kct_pkg::USED_W'($countones(r_vld)))
        else $error("entry count out of step with valid bits");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_take |-> r_st == kct_pkg::BK_IDLE) else $error("take while busy");
    a_exec_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == kct_pkg::BK_READ |=> r_st == kct_pkg::BK_EXEC)
        else $error("read not followed by execute");

endmodule

[rtl/keyed_counter_table.sv]
// Keyed counter table: a table of (key, count) entries served as a multiset.
// Request channel: i_valid/o_stall with kind, key, quantity; one result per
// request on o_valid/i_stall with status, held amount, has-enough flag,
// entries in use and total held.
// A front queue of two items takes requests while the back is busy; the back
// runs each request in turn (take and compare all keys in parallel,
// read the count memory, update and register the result) and takes no new
// item until it is back in idle, set by the three-state back sequence.
// With no stall, o_valid rises when the execute state loads the result register.
// An add of a new key takes the lowest free entry; no free entry gives a
// table-full status. A count past 32 bits saturates with its own status.
// Reset (synchronous, active low) empties the queue and clears all entry
// valid bits and totals at once; no clearing pass is needed.
// While the receiver stalls, the result holds; the back waits, and the front
// keeps accepting until its queue is full, then raises o_stall.
module keyed_counter_table #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned KEY_BITS      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [kct_pkg::KIND_W-1:0]  i_kind,
    input  logic [kct_pkg::IKEY_W-1:0]  i_item_key,
    input  logic [kct_pkg::QTY_W-1:0]   i_quantity,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [kct_pkg::STAT_W-1:0]  o_status,
    output logic [kct_pkg::QTY_W-1:0]   o_held_amount,
    output logic                        o_has_enough,
    output logic [kct_pkg::USED_W-1:0]  o_entries_used,
    output logic [kct_pkg::SUM_W-1:0]   o_total_held
);

    logic          req_valid;
    logic          req_take;
    kct_pkg::t_req req;

    // front: accept and queue
    kct_front #(.KEY_BITS(KEY_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_item_key  (i_item_key),
        .i_quantity  (i_quantity),
        .o_req_valid (req_valid),
        .i_req_take  (req_take),
        .o_req       (req)
    );

    // back: lookup, update, result
    kct_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (req_valid),
        .o_req_take     (req_take),
        .i_req          (req),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_held_amount  (o_held_amount),
        .o_has_enough   (o_has_enough),
        .o_entries_used (o_entries_used),
        .o_total_held   (o_total_held)
    );

endmodule

[dv/keyed_counter_table_tb.sv]
// Testbench for keyed_counter_table: drives add/take/query items, predicts each
// result with a scoreboard model of the table, compares field by field.
// Depends on rtl/kct_pkg.sv and rtl/keyed_counter_table.sv.
module keyed_counter_table_tb;

    localparam int N_ENT   = 64;
    localparam int LIMIT   = 400000;
    localparam int N_RAND  = 1600;

    // Unused kind code, served as a query
    localparam logic [kct_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [kct_pkg::KIND_W-1:0] kind;
        logic [kct_pkg::IKEY_W-1:0] key;
        logic [kct_pkg::QTY_W-1:0]  qty;
    } t_op;

    typedef struct packed {
        logic [kct_pkg::STAT_W-1:0] status;
        logic [kct_pkg::QTY_W-1:0]  held;
        logic                       enough;
        logic [kct_pkg::USED_W-1:0] used;
        logic [kct_pkg::SUM_W-1:0]  sum;
    } t_res;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0;
    logic [kct_pkg::KIND_W-1:0] i_kind = '0;
    logic [kct_pkg::IKEY_W-1:0] i_item_key = '0;
    logic [kct_pkg::QTY_W-1:0]  i_quantity = '0;
    logic o_stall, o_valid, o_has_enough;
    logic [kct_pkg::STAT_W-1:0] o_status;
    logic [kct_pkg::QTY_W-1:0]  o_held_amount;
    logic [kct_pkg::USED_W-1:0] o_entries_used;
    logic [kct_pkg::SUM_W-1:0]  o_total_held;

    keyed_counter_table i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Scoreboard copy of the table
    logic [kct_pkg::IKEY_W-1:0] tbl_key [N_ENT];
    logic [kct_pkg::QTY_W-1:0]  tbl_cnt [N_ENT];
    logic                       tbl_vld [N_ENT];
    logic [kct_pkg::USED_W-1:0] tbl_used;
    logic [kct_pkg::SUM_W-1:0]  tbl_sum;

    t_op  pending_ops[$];
    t_res expected_res[$];
    int   n_errors = 0;
    int   cycles = 0;
    bit   stim_done = 0;
    int   hold_len = 0;
    bit   hold_on = 0;
    logic [kct_pkg::IKEY_W-1:0] key_pool[8];

    function automatic t_res table_apply(t_op op);
        t_res r;
        int slot, free_slot;
        logic [kct_pkg::QTY_W-1:0] cnt_old;
        logic [kct_pkg::QTY_W:0] s;
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < N_ENT; i++) begin
            if (tbl_vld[i] && tbl_key[i] == op.key && slot < 0) slot = i;
            if (!tbl_vld[i] && free_slot < 0) free_slot = i;
        end
        cnt_old = (slot >= 0) ? tbl_cnt[slot] : '0;
        r.status = kct_pkg::ST_OK;
        r.held = cnt_old;
        r.enough = (cnt_old >= op.qty);
        if (op.kind == kct_pkg::KIND_ADD) begin
            if (slot >= 0) begin
                s = {1'b0, cnt_old} + {1'b0, op.qty};
                if (s[kct_pkg::QTY_W]) begin
                    s = {1'b0, {kct_pkg::QTY_W{1'b1}}};
                    r.status = kct_pkg::ST_SAT;
                end
                tbl_cnt[slot] = s[kct_pkg::QTY_W-1:0];
                tbl_sum = tbl_sum + kct_pkg::SUM_W'(s[kct_pkg::QTY_W-1:0] - cnt_old);
                r.held = s[kct_pkg::QTY_W-1:0];
            end else if (free_slot < 0) begin
                r.status = kct_pkg::ST_FULL;
                r.held = '0;
            end else begin
                tbl_vld[free_slot] = 1;
                tbl_key[free_slot] = op.key;
                tbl_cnt[free_slot] = op.qty;
                tbl_used++;
                tbl_sum = tbl_sum + kct_pkg::SUM_W'(op.qty);
                r.held = op.qty;
            end
        end else if (op.kind == kct_pkg::KIND_TAKE) begin
            if (slot < 0) begin
                r.status = kct_pkg::ST_ABSENT;
                r.held = '0;
            end else if (cnt_old < op.qty) begin
                r.status = kct_pkg::ST_SHORT;
            end else begin
                r.held = cnt_old - op.qty;
                tbl_cnt[slot] = r.held;
                tbl_sum = tbl_sum - kct_pkg::SUM_W'(op.qty);
                if (r.held == 0) begin
                    tbl_vld[slot] = 0;
                    tbl_used--;
                end
            end
        end
        r.used = tbl_used;
        r.sum = tbl_sum;
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        n_errors++;
    endtask

    function automatic logic [kct_pkg::QTY_W-1:0] rand_qty();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3: return kct_pkg::QTY_W'($urandom_range(1, 3));
            default: return kct_pkg::QTY_W'($urandom_range(0, 1000));
        endcase
    endfunction

    task automatic push(logic [kct_pkg::KIND_W-1:0] k, logic [kct_pkg::IKEY_W-1:0] key,
                        logic [kct_pkg::QTY_W-1:0] q);
        t_op op;
        op.kind = k;
        op.key = key;
        op.qty = q;
        pending_ops.push_back(op);
    endtask

    // Driver: offers pending items, with a random gap before each one
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_res.push_back(table_apply({i_kind, i_item_key, i_quantity}));
                send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 0;
                end else if (pending_ops.size() > 0) begin
                    t_op op;
                    op = pending_ops.pop_front();
                    i_valid <= 1;
                    i_kind <= op.kind;
                    i_item_key <= op.key;
                    i_quantity <= op.qty;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down in its own process
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            hold_on <= 1'b1;
            hold_len <= hold_len - 1;
        end else begin
            hold_on <= 1'b0;
        end
    end

    // Monitor: checks results and draws receiver stalls
    int recv_gap = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_res.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    t_res e;
                    e = expected_res.pop_front();
                    if (o_status != e.status) report("status", o_status, e.status);
                    if (o_held_amount != e.held) report("held_amount", o_held_amount, e.held);
                    if (o_has_enough != e.enough) report("has_enough", o_has_enough, e.enough);
                    if (o_entries_used != e.used) report("entries_used", o_entries_used, e.used);
                    if (o_total_held != e.sum) report("total_held", o_total_held, e.sum);
                end
                recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
            end
            if (hold_on) begin
                i_stall <= 1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1;
            end else begin
                i_stall <= 0;
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < N_ENT; i++) begin
            tbl_vld[i] = 0;
            tbl_key[i] = '0;
            tbl_cnt[i] = '0;
        end
        tbl_used = '0;
        tbl_sum = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: absent take, zero add, saturation, short take, zero take, kind 3
        push(kct_pkg::KIND_TAKE, 16'h1234, 5);
        push(kct_pkg::KIND_QUERY, 16'h1234, 0);
        push(kct_pkg::KIND_ADD, 16'h0000, 0);
        push(kct_pkg::KIND_ADD, 16'hFFFF, '1);
        push(kct_pkg::KIND_ADD, 16'hFFFF, 1);
        push(kct_pkg::KIND_QUERY, 16'hFFFF, '1);
        push(kct_pkg::KIND_TAKE, 16'h0000, 1);
        push(kct_pkg::KIND_TAKE, 16'h0000, 0);
        push(kct_pkg::KIND_ADD, 16'hAAAA, 10);
        push(kct_pkg::KIND_TAKE, 16'hAAAA, 11);
        push(KIND_SPARE, 16'hAAAA, 10);
        push(kct_pkg::KIND_TAKE, 16'hAAAA, 10);
        push(kct_pkg::KIND_TAKE, 16'hFFFF, '1);
        push(kct_pkg::KIND_ADD, 16'h5555, 32'h8000_0000);
        push(kct_pkg::KIND_QUERY, 16'h5555, 32'h8000_0001);
        // Fill the table past capacity, then free one and refill lowest slot
        for (int i = 0; i < 66; i++)
            push(kct_pkg::KIND_ADD, kct_pkg::IKEY_W'(16'h0100 + i), '1);
        push(kct_pkg::KIND_TAKE, 16'h0105, '1);
        push(kct_pkg::KIND_ADD, 16'h0200, 7);
        for (int i = 0; i < 66; i++)
            push(kct_pkg::KIND_TAKE, kct_pkg::IKEY_W'(16'h0100 + i), '1);
        push(kct_pkg::KIND_TAKE, 16'h0200, 7);
        push(kct_pkg::KIND_TAKE, 16'h5555, 32'h8000_0000);

        // Long receiver hold-off while the sender keeps offering
        wait (pending_ops.size() < 100);
        hold_len = 60;

        // Random: mostly a small pool of keys so adds and takes meet
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
        for (int i = 0; i < N_RAND; i++) begin
            logic [kct_pkg::IKEY_W-1:0] k;
            logic [kct_pkg::KIND_W-1:0] kd;
            k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)]
                : ($urandom_range(0, 1) ? kct_pkg::IKEY_W'($urandom_range(0, 90))
                                        : kct_pkg::IKEY_W'($urandom));
            kd = ($urandom_range(0, 19) == 0) ? KIND_SPARE
                                              : kct_pkg::KIND_W'($urandom_range(0, 2));
            push(kd, k, rand_qty());
            if (i == N_RAND / 2) begin
                wait (pending_ops.size() == 0);
                hold_len = 80;
            end
        end
        wait (pending_ops.size() == 0 && !i_valid);
        wait (expected_res.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && expected_res.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[files.f]
rtl/kct_pkg.sv
rtl/kct_front.sv
rtl/kct_back.sv
rtl/keyed_counter_table.sv
dv/keyed_counter_table_tb.sv
